// ===== rtl/core/bfmc_pkg.sv =====
// Shared types, constants and lane arithmetic for the box-filter mip chain.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package bfmc_pkg;

    // Field widths fixed by the interface.
    localparam int SIZE_W   = 13;   // image sizes and raster counters
    localparam int LEVEL_W  = 4;    // mip level number
    localparam int COORD_W  = 11;   // texel coordinates
    localparam int PIX_W    = 32;   // RGBA8 pixel
    localparam int LANE_W   = 9;    // one channel of a pair sum
    localparam int LANES_W  = 4 * LANE_W;
    localparam int OUT_DATA_W = 56; // x, y and texel padded to whole bytes

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd2;

    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_READ,
        CELL_EMIT
    } cell_state_t;

    // Pixel handed from one level cell to the next.
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
    } token_t;

    // Finished texel offered by a cell to the output register.
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   texel;
        logic               last;
    } emit_t;

    // Access request to the row pair-sum memory.
    typedef struct packed {
        logic               we;
        logic               re;
        logic [LANES_W-1:0] wdata;
    } mem_op_t;

    // Widen the four bytes of a pixel into 9-bit lanes.
    function automatic logic [LANES_W-1:0] spread_lanes(input logic [PIX_W-1:0] p);
        logic [LANES_W-1:0] s;
        s = '0;
        for (int i = 0; i < 4; i++) begin
            s[i*LANE_W +: LANE_W] = {1'b0, p[i*8 +: 8]};
        end
        return s;
    endfunction

    // Lane-wise sum; each lane keeps 9 bits.
    function automatic logic [LANES_W-1:0] add_lanes(input logic [LANES_W-1:0] a,
                                                     input logic [LANES_W-1:0] b);
        logic [LANES_W-1:0] s;
        s = '0;
        for (int i = 0; i < 4; i++) begin
            s[i*LANE_W +: LANE_W] = a[i*LANE_W +: LANE_W] + b[i*LANE_W +: LANE_W];
        end
        return s;
    endfunction

    // Sum two pair sums per channel and divide by four, truncating.
    function automatic logic [PIX_W-1:0] average_lanes(input logic [LANES_W-1:0] a,
                                                       input logic [LANES_W-1:0] b);
        logic [PIX_W-1:0]  t;
        logic [LANE_W:0]   s;
        t = '0;
        for (int i = 0; i < 4; i++) begin
            s = {1'b0, a[i*LANE_W +: LANE_W]} + {1'b0, b[i*LANE_W +: LANE_W]};
            t[i*8 +: 8] = s[LANE_W:2];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfmc_sum_ram.sv =====
// Single-port memory holding the horizontal pair sums of even rows.
// Depends on bfmc_pkg for the lane width.
`default_nettype none

module bfmc_sum_ram #(
    parameter int MAX_WIDTH = 4096,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic                         re,
    input  wire logic [AW-1:0]                addr,
    input  wire logic [bfmc_pkg::LANES_W-1:0] wdata,
    output logic      [bfmc_pkg::LANES_W-1:0] rdata
);

    logic [bfmc_pkg::LANES_W-1:0] mem [MAX_WIDTH];
    logic [bfmc_pkg::LANES_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bfmc_cell.sv =====
// One level of the mip chain: raster counters, the held left pixel, level
// geometry and the pair/average step. Depends on bfmc_pkg.
`default_nettype none

module bfmc_cell #(
    parameter int MAX_WIDTH = 4096,
    parameter int LEVEL = 0,
    parameter bit LAST_CELL = 1'b0,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          enable,
    input  wire logic [bfmc_pkg::SIZE_W-1:0]   w_in,
    input  wire logic [bfmc_pkg::SIZE_W-1:0]   h_in,
    input  wire logic [AW-1:0]                 off_in,
    output logic      [bfmc_pkg::SIZE_W-1:0]   w_out,
    output logic      [bfmc_pkg::SIZE_W-1:0]   h_out,
    output logic      [AW-1:0]                 off_out,
    input  wire bfmc_pkg::token_t              tok_in,
    output bfmc_pkg::token_t                   tok_out,
    input  wire logic                          next_emits,
    output logic                               emits,
    input  wire logic                          out_ready,
    output bfmc_pkg::emit_t                    emit,
    output bfmc_pkg::mem_op_t                  mem_op,
    output logic      [AW-1:0]                 mem_addr,
    input  wire logic [bfmc_pkg::LANES_W-1:0]  rdata,
    output logic                               done
);

    localparam int SW = bfmc_pkg::SIZE_W;
    localparam int CW = bfmc_pkg::COORD_W;
    localparam int SHIFT = 26;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'((64'd1 << SHIFT) / MAX_WIDTH);
    localparam int MW = 16;
    localparam logic [MW-1:0] MAXW = MW'(MAX_WIDTH);
    localparam logic [AW:0] DEPTH_X = (AW+1)'(MAX_WIDTH);

    bfmc_pkg::cell_state_t state_reg, state_next;

    logic [SW-1:0]                col_reg, col_next;
    logic [SW-1:0]                row_reg, row_next;
    logic                         tok_valid_reg, tok_valid_next;
    logic [bfmc_pkg::PIX_W-1:0]   held_reg, held_next;
    logic [bfmc_pkg::LANES_W-1:0] pair_reg, pair_next;
    logic [bfmc_pkg::PIX_W-1:0]   texel_reg, texel_next;
    logic [CW-1:0]                x_reg, x_next;
    logic [CW-1:0]                y_reg, y_next;
    logic [AW-1:0]                addr_reg, addr_next;

    // Geometry of the level below, worked out in registered steps.
    logic [SW-1:0]       nw_reg, nw_next;
    logic [SW-1:0]       nh_reg, nh_next;
    logic [SW+SHIFT-1:0] prod_reg, prod_next;
    logic [SW-1:0]       qm_reg, qm_next;
    logic [AW-1:0]       mod_reg, mod_next;
    logic [AW-1:0]       off_reg, off_next;

    logic [SW-1:0]    half_w, half_h;
    logic [SW-1:0]    quot;
    logic [SW+MW-1:0] qm_full;
    logic [SW-1:0]    rem;
    logic [AW:0]      off_sum;

    logic [SW:0]                  col_ext, row_ext;
    logic                         col_wrap, row_wrap;
    logic                         w_one, h_one;
    logic [bfmc_pkg::PIX_W-1:0]   left_pixel;
    logic [bfmc_pkg::LANES_W-1:0] pair;
    logic [AW-1:0]                addr_use;
    logic [AW:0]                  addr_inc;
    logic [AW-1:0]                addr_step;

    // Geometry: next size is half this one but at least one; the next
    // level's memory region starts after this level's entries.
    always_comb
    begin
        half_w    = w_in >> 1;
        half_h    = h_in >> 1;
        nw_next   = (half_w == '0) ? SW'(1) : half_w;
        nh_next   = (half_h == '0) ? SW'(1) : half_h;
        prod_next = nw_reg * RECIP;
        quot      = prod_reg[SHIFT +: SW];
        qm_full   = quot * MAXW;
        qm_next   = qm_full[SW-1:0];
        rem       = nw_reg - qm_reg;
        mod_next  = (MW'(rem) >= MAXW) ? AW'(MW'(rem) - MAXW) : AW'(rem);
        off_sum   = {1'b0, off_in} + {1'b0, mod_reg};
        off_next  = (off_sum >= DEPTH_X) ? AW'(off_sum - DEPTH_X) : off_sum[AW-1:0];
    end

    always_comb
    begin
        col_ext    = {1'b0, col_reg} + (SW+1)'(1);
        row_ext    = {1'b0, row_reg} + (SW+1)'(1);
        col_wrap   = col_ext >= {1'b0, w_in};
        row_wrap   = row_ext >= {1'b0, h_in};
        w_one      = w_in == SW'(1);
        h_one      = h_in == SW'(1);
        left_pixel = w_one ? tok_in.pixel : held_reg;
        pair       = bfmc_pkg::add_lanes(bfmc_pkg::spread_lanes(left_pixel),
                                         bfmc_pkg::spread_lanes(tok_in.pixel));
        addr_use   = (col_reg == '0) ? off_in : addr_reg;
        addr_inc   = {1'b0, addr_reg} + (AW+1)'(1);
        addr_step  = (addr_inc == DEPTH_X) ? '0 : addr_inc[AW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        held_next      = held_reg;
        pair_next      = pair_reg;
        texel_next     = texel_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        addr_next      = addr_reg;
        tok_valid_next = 1'b0;
        done           = 1'b0;
        mem_op         = '0;
        mem_addr       = '0;
        emit           = '0;

        unique case (state_reg)
            bfmc_pkg::CELL_IDLE:
            begin
                if (tok_in.valid)
                begin
                    if (!enable)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        col_next = col_wrap ? '0 : col_ext[SW-1:0];
                        if (col_wrap)
                        begin
                            row_next = row_wrap ? '0 : row_ext[SW-1:0];
                        end
                        x_next = col_reg[CW:1];
                        y_next = row_reg[CW:1];
                        if (col_reg == '0)
                        begin
                            addr_next = off_in;
                        end

                        if (!(w_one || col_reg[0]))
                        begin
                            // Even column: wait for the right-hand partner.
                            held_next = tok_in.pixel;
                            done      = 1'b1;
                        end
                        else
                        begin
                            if (!w_one)
                            begin
                                addr_next = addr_step;
                            end
                            if (h_one)
                            begin
                                texel_next = bfmc_pkg::average_lanes(pair, pair);
                                state_next = bfmc_pkg::CELL_EMIT;
                            end
                            else if (!row_reg[0])
                            begin
                                // Even row: park the pair sum unless this row is dropped.
                                mem_op.we    = !row_wrap;
                                mem_op.wdata = pair;
                                mem_addr     = addr_use;
                                done         = 1'b1;
                            end
                            else
                            begin
                                mem_op.re  = 1'b1;
                                mem_addr   = addr_use;
                                pair_next  = pair;
                                state_next = bfmc_pkg::CELL_READ;
                            end
                        end
                    end
                end
            end
            bfmc_pkg::CELL_READ:
            begin
                texel_next = bfmc_pkg::average_lanes(rdata, pair_reg);
                state_next = bfmc_pkg::CELL_EMIT;
            end
            bfmc_pkg::CELL_EMIT:
            begin
                emit.valid = 1'b1;
                emit.level = bfmc_pkg::LEVEL_W'(LEVEL + 1);
                emit.x     = x_reg;
                emit.y     = y_reg;
                emit.texel = texel_reg;
                emit.last  = LAST_CELL ? 1'b1 : !next_emits;
                if (out_ready)
                begin
                    state_next = bfmc_pkg::CELL_IDLE;
                    if (LAST_CELL)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        tok_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = bfmc_pkg::CELL_IDLE;
            end
        endcase

        if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfmc_pkg::CELL_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg  <= held_next;
        pair_reg  <= pair_next;
        texel_reg <= texel_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        addr_reg  <= addr_next;
        nw_reg    <= nw_next;
        nh_reg    <= nh_next;
        prod_reg  <= prod_next;
        qm_reg    <= qm_next;
        mod_reg   <= mod_next;
        off_reg   <= off_next;
    end

    assign emits         = enable && (w_one || col_reg[0]) && (h_one || row_reg[0]);
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.pixel = texel_reg;
    assign w_out         = nw_reg;
    assign h_out         = nh_reg;
    assign off_out       = off_reg;

endmodule

`default_nettype wire

// ===== rtl/core/box_filter_mip_chain.sv =====
// Top level of the streaming 2x2 box-filter mip chain generator.
// Depends on bfmc_pkg, bfmc_cell and bfmc_sum_ram.
//
//   Channel        Direction  Transfer when          Contents
//   cfg            in         cfg_we high           cfg_index, cfg_data
//   s_axis         in         tvalid and tready     tdata: source pixel RGBA8
//   m_axis         out        tvalid and tready     tdata: x, y, texel; tuser: level;
//                                                    tlast: last texel of a pixel
//
// A source pixel that completes no texel finishes in the cycle it is taken. Each
// texel it causes is evaluated in its level, read back through the registered read
// of the single-port pair-sum memory (skipped on a level one row high), and held in
// the cell's output stage, after which the texel moves on to the next level's cell.
// A texel from the last cell of the chain ends the pixel in that output stage,
// as no further cell has to look at it. Reset and every write to a listed
// register return all raster counters to zero; afterwards tready stays low
// while the level sizes and memory offsets ripple down the chain. A stalled
// m_axis holds the emitting cell in its output stage, and no new pixel is
// taken until the previous one has finished.
`default_nettype none

module box_filter_mip_chain #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_LEVELS = 13
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bfmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bfmc_pkg::SIZE_W-1:0]       cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pixel_rgba [31:0]
    input  wire logic [bfmc_pkg::PIX_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // texel_x [10:0], texel_y [21:11], texel_rgba [53:22], zero [55:54]
    output logic      [bfmc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // mip_level [3:0]
    output logic      [bfmc_pkg::LEVEL_W-1:0]      m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int NCELL  = MAX_LEVELS - 1;
    localparam int SETTLE = MAX_LEVELS + 6;
    localparam int STW    = $clog2(SETTLE + 1);
    localparam int SW     = bfmc_pkg::SIZE_W;
    localparam int LW     = bfmc_pkg::LEVEL_W;

    // Configuration registers.
    logic [SW-1:0] src_width_reg, src_width_next;
    logic [SW-1:0] src_height_reg, src_height_next;
    logic [LW-1:0] level_count_reg, level_count_next;
    logic          cfg_hit;
    logic [LW-1:0] lc_eff;

    logic [STW-1:0] settle_reg, settle_next;
    logic           busy_reg, busy_next;
    logic           accept;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [LW-1:0]                out_level_reg;
    logic [bfmc_pkg::COORD_W-1:0] out_x_reg;
    logic [bfmc_pkg::COORD_W-1:0] out_y_reg;
    logic [bfmc_pkg::PIX_W-1:0]   out_texel_reg;
    logic                         out_last_reg;
    logic                         out_ready;

    // Cell chain.
    logic [SW-1:0]     w_chain   [NCELL+1];
    logic [SW-1:0]     h_chain   [NCELL+1];
    logic [AW-1:0]     off_chain [NCELL+1];
    bfmc_pkg::token_t  tok_chain [NCELL+1];
    bfmc_pkg::emit_t   emit_arr  [NCELL];
    bfmc_pkg::mem_op_t op_arr    [NCELL];
    logic [AW-1:0]     addr_arr  [NCELL];
    logic [NCELL:0]    emits_ext;
    logic [NCELL-1:0]  done_vec;
    logic [NCELL-1:0]  enable_vec;

    bfmc_pkg::emit_t              emit_any;
    bfmc_pkg::mem_op_t            op_any;
    logic [AW-1:0]                addr_any;
    logic                         done_any;
    logic [bfmc_pkg::LANES_W-1:0] rdata;

    // Configuration writes; any listed register restarts the image.
    always_comb
    begin
        src_width_next   = src_width_reg;
        src_height_next  = src_height_reg;
        level_count_next = level_count_reg;
        cfg_hit          = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bfmc_pkg::CFG_SRC_WIDTH:
                begin
                    src_width_next = cfg_data;
                    cfg_hit        = 1'b1;
                end
                bfmc_pkg::CFG_SRC_HEIGHT:
                begin
                    src_height_next = cfg_data;
                    cfg_hit         = 1'b1;
                end
                bfmc_pkg::CFG_LEVEL_COUNT:
                begin
                    level_count_next = cfg_data[LW-1:0];
                    cfg_hit          = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // A level count of zero behaves as one; counts above the chain saturate.
    always_comb
    begin
        priority if (level_count_reg == '0)
        begin
            lc_eff = LW'(1);
        end
        else if (level_count_reg > LW'(MAX_LEVELS))
        begin
            lc_eff = LW'(MAX_LEVELS);
        end
        else
        begin
            lc_eff = level_count_reg;
        end
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg && (settle_reg == '0);
    assign out_ready     = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_hit)
        begin
            settle_next = STW'(SETTLE);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - STW'(1);
        end

        // A pixel that ends in level zero finishes in the cycle it is taken.
        if (accept)
        begin
            busy_next = !done_any;
        end
        else
        begin
            busy_next = busy_reg && !done_any;
        end

        out_valid_next = out_valid_reg;
        if (emit_any.valid && out_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= SW'(1024);
            src_height_reg  <= SW'(1024);
            level_count_reg <= LW'(11);
            settle_reg      <= STW'(SETTLE);
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            src_width_reg   <= src_width_next;
            src_height_reg  <= src_height_next;
            level_count_reg <= level_count_next;
            settle_reg      <= settle_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_any.valid && out_ready)
        begin
            out_level_reg <= emit_any.level;
            out_x_reg     <= emit_any.x;
            out_y_reg     <= emit_any.y;
            out_texel_reg <= emit_any.texel;
            out_last_reg  <= emit_any.last;
        end
    end

    // Level zero geometry; a zero size behaves as one.
    assign w_chain[0]   = (src_width_reg == '0) ? SW'(1) : src_width_reg;
    assign h_chain[0]   = (src_height_reg == '0) ? SW'(1) : src_height_reg;
    assign off_chain[0] = '0;
    assign tok_chain[0] = '{valid: accept, pixel: s_axis_tdata};
    assign emits_ext[NCELL] = 1'b0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        assign enable_vec[i] = LW'(i + 1) < lc_eff;

        bfmc_cell #(
            .MAX_WIDTH (MAX_WIDTH),
            .LEVEL     (i),
            .LAST_CELL (i == NCELL - 1)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .clear      (cfg_hit),
            .enable     (enable_vec[i]),
            .w_in       (w_chain[i]),
            .h_in       (h_chain[i]),
            .off_in     (off_chain[i]),
            .w_out      (w_chain[i+1]),
            .h_out      (h_chain[i+1]),
            .off_out    (off_chain[i+1]),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1]),
            .next_emits (emits_ext[i+1]),
            .emits      (emits_ext[i]),
            .out_ready  (out_ready),
            .emit       (emit_arr[i]),
            .mem_op     (op_arr[i]),
            .mem_addr   (addr_arr[i]),
            .rdata      (rdata),
            .done       (done_vec[i])
        );
    end

    // Only one cell holds the pixel at a time, so the requests merge by OR.
    always_comb
    begin
        emit_any = '0;
        op_any   = '0;
        addr_any = '0;
        for (int i = 0; i < NCELL; i++)
        begin
            emit_any = bfmc_pkg::emit_t'(emit_any | emit_arr[i]);
            op_any   = bfmc_pkg::mem_op_t'(op_any | op_arr[i]);
            addr_any = addr_any | addr_arr[i];
        end
        done_any = |done_vec;
    end

    bfmc_sum_ram #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (op_any.we),
        .re    (op_any.re),
        .addr  (addr_any),
        .wdata (op_any.wdata),
        .rdata (rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_texel_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_level_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for box_filter_mip_chain: streams RGBA8 source pixels,
// predicts every mip texel in step with the accepted transfers and checks the output.
// Depends on bfmc_pkg for the port widths and register indexes; needs nothing else.

module testbench;

    // Run shape.
    localparam int IDLE_PERCENT  = 22;   // chance in a hundred that a side idles in a cycle
    localparam int LONG_HOLD     = 200;  // cycles for which the receiver backs off once
    localparam int SETTLE_CYCLES = 64;   // up to twelve texels, with margin
    localparam int DRAIN_LIMIT   = 50000;
    localparam int RANDOM_ITEMS  = 200;

    // Shape of the block as the predictor sees it.
    localparam int STORE_DEPTH = 4096;   // MAX_WIDTH of the block
    localparam int LEVEL_SLOTS = 13;     // MAX_LEVELS of the block
    localparam int MAX_RESULTS = 12;

    // The index after the three listed registers; the block must ignore writes to it.
    localparam logic [bfmc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One expected texel, in the order of the fields on the output side.
    typedef struct packed {
        logic [bfmc_pkg::LEVEL_W-1:0] level;
        logic [bfmc_pkg::COORD_W-1:0] x;
        logic [bfmc_pkg::COORD_W-1:0] y;
        logic [bfmc_pkg::PIX_W-1:0]   rgba;
        logic                         last;
    } texel_t;

    // Horizontal sum of two pixels, one 9-bit lane per channel.
    typedef struct packed {
        logic [8:0] alpha;
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } lane_sum_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                                cfg_we    = 1'b0;
    logic [bfmc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [bfmc_pkg::SIZE_W-1:0]         cfg_data  = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // pixel_rgba [31:0]
    logic [bfmc_pkg::PIX_W-1:0]          s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // texel_x [10:0], texel_y [21:11], texel_rgba [53:22], zero [55:54]
    logic [bfmc_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    // mip_level [3:0]
    logic [bfmc_pkg::LEVEL_W-1:0]        m_axis_tuser;
    logic                                m_axis_tlast;

    box_filter_mip_chain i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Pixels waiting to be offered, and texels waiting to come out, oldest first.
    logic [bfmc_pkg::PIX_W-1:0] pending_pixels[$];
    texel_t                     awaited_texels[$];
    int                         pixels_queued   = 0;
    int                         pixels_taken    = 0;
    int                         error_count     = 0;

    // Control of the idling from the stimulus process. While steady is high neither
    // side idles; each toggle of hold_request starts one long receiver hold-off.
    logic steady       = 1'b0;
    logic hold_request = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    // Shadow of the configuration registers, at their reset values.
    int unsigned shadow_cols  = 1024;
    int unsigned shadow_rows  = 1024;
    int unsigned level_total  = 11;

    // Shadow of the block's storage. The raster position of every level starts at
    // zero; the held pixels and pair sums are only ever read after being written.
    int unsigned level_col [LEVEL_SLOTS];
    int unsigned level_row [LEVEL_SLOTS];
    logic [31:0] held_left [LEVEL_SLOTS];
    lane_sum_t   pair_store [STORE_DEPTH];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the whole run, far beyond the slowest correct one.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void restart_image();
        for (int i = 0; i < LEVEL_SLOTS; i++)
        begin
            level_col[i] = 0;
            level_row[i] = 0;
        end
    endfunction

    function automatic lane_sum_t lane_pair(input logic [31:0] left, input logic [31:0] right);
        lane_sum_t s;
        s.red   = {1'b0, left[7:0]}   + {1'b0, right[7:0]};
        s.green = {1'b0, left[15:8]}  + {1'b0, right[15:8]};
        s.blue  = {1'b0, left[23:16]} + {1'b0, right[23:16]};
        s.alpha = {1'b0, left[31:24]} + {1'b0, right[31:24]};
        return s;
    endfunction

    // Four-pixel sum per channel divided by four, dropping the remainder.
    function automatic logic [31:0] box_average(input lane_sum_t upper, input lane_sum_t lower);
        logic [9:0] r, g, b, a;
        r = {1'b0, upper.red}   + {1'b0, lower.red};
        g = {1'b0, upper.green} + {1'b0, lower.green};
        b = {1'b0, upper.blue}  + {1'b0, lower.blue};
        a = {1'b0, upper.alpha} + {1'b0, lower.alpha};
        return {a[9:2], b[9:2], g[9:2], r[9:2]};
    endfunction

    // Advance the mip chain by one accepted source pixel and queue every texel it
    // finishes. A finished texel is passed down as a pixel of its own level, so the
    // walk goes on until some level waits for a partner pixel or row, or the levels run out.
    function automatic void predict_texels(input logic [31:0] pixel);
        int unsigned levels, w, h, next_w, next_h, base, c, r, x, y, idx, level_no;
        int          n;
        logic [31:0] p, texel;
        lane_sum_t   pair;
        texel_t      run [MAX_RESULTS];
        levels = level_total;
        if (levels < 1)
            levels = 1;
        if (levels > LEVEL_SLOTS)
            levels = LEVEL_SLOTS;
        w = (shadow_cols != 0) ? shadow_cols : 1;
        h = (shadow_rows != 0) ? shadow_rows : 1;
        p = pixel;
        base = 0;
        n = 0;
        for (int lvl = 0; lvl + 1 < int'(levels); lvl++)
        begin
            c = level_col[lvl];
            r = level_row[lvl];
            next_w = (w / 2 != 0) ? w / 2 : 1;
            next_h = (h / 2 != 0) ? h / 2 : 1;
            // Raster step, wrapping into a new image after the last pixel.
            if (c + 1 >= w)
            begin
                level_col[lvl] = 0;
                level_row[lvl] = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                level_col[lvl] = c + 1;

            // Horizontal pairing; a level one column wide pairs each pixel with itself,
            // and an odd last column is dropped.
            if (w == 1)
                pair = lane_pair(p, p);
            else if ((c & 1) == 0)
            begin
                if (c + 1 < w)
                    held_left[lvl] = p;
                break;
            end
            else
                pair = lane_pair(held_left[lvl], p);

            x = c >> 1;
            y = r >> 1;
            idx = (base + x) % STORE_DEPTH;

            // Vertical pairing, in the same way for rows.
            if (h == 1)
                texel = box_average(pair, pair);
            else if ((r & 1) == 0)
            begin
                if (r + 1 < h)
                    pair_store[idx] = pair;
                break;
            end
            else
                texel = box_average(pair_store[idx], pair);

            level_no = lvl + 1;
            run[n].level = level_no[3:0];
            run[n].x     = x[10:0];
            run[n].y     = y[10:0];
            run[n].rgba  = texel;
            run[n].last  = 1'b0;
            n++;

            p = texel;
            base += next_w;
            w = next_w;
            h = next_h;
        end
        if (n > 0)
            run[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_texels.push_back(run[i]);
    endfunction

    task automatic report_mismatch(input string line);
        error_count++;
        if (error_count <= 200)
            $display("error: %s", line);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input texel_t ref_texel);
        if (got !== want)
            report_mismatch($sformatf("texel of level %0d at (%0d,%0d): %s is %h, expected %h",
                                      ref_texel.level, ref_texel.x, ref_texel.y,
                                      name, got, want));
    endtask

    // Source side. A pixel is predicted at the edge where its transfer completes;
    // the offer then stays put, moves on to the next pending pixel or is withdrawn.
    always @(posedge clk)
    begin : pixel_driver
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_texels(s_axis_tdata);
                pixels_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pixels.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pixels.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The long hold-off of the receiver, counted here so that the stimulus process
    // only has to ask for it.
    always @(posedge clk)
    begin : hold_counter
        if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result side: every completed transfer is matched against the oldest awaited texel.
    always @(posedge clk)
    begin : texel_monitor
        texel_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_texels.size() == 0)
                    report_mismatch($sformatf("texel of level %0d at (%0d,%0d) not expected",
                                              m_axis_tuser, m_axis_tdata[10:0],
                                              m_axis_tdata[21:11]));
                else
                begin
                    want = awaited_texels.pop_front();
                    check_field("mip_level", {28'b0, m_axis_tuser}, {28'b0, want.level}, want);
                    check_field("texel_x", {21'b0, m_axis_tdata[10:0]}, {21'b0, want.x}, want);
                    check_field("texel_y", {21'b0, m_axis_tdata[21:11]}, {21'b0, want.y}, want);
                    check_field("texel_rgba", m_axis_tdata[53:22], want.rgba, want);
                    check_field("last_of_run", {31'b0, m_axis_tlast}, {31'b0, want.last}, want);
                end
            end
            m_axis_tready <= (hold_left == 0) &&
                             (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Nothing is in flight once every queued pixel has been taken and predicted and
    // every predicted texel has come out. A pixel may still be in the level cells
    // after its last texel has come out, so a margin of SETTLE_CYCLES is added.
    task automatic wait_quiet();
        while (pixels_taken != pixels_queued || awaited_texels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A register write also starts a new image, except at the unused index.
    task automatic write_reg(input logic [bfmc_pkg::CFG_IDX_W-1:0] index,
                             input logic [bfmc_pkg::SIZE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            bfmc_pkg::CFG_SRC_WIDTH:   shadow_cols  = {19'b0, value};
            bfmc_pkg::CFG_SRC_HEIGHT:  shadow_rows  = {19'b0, value};
            bfmc_pkg::CFG_LEVEL_COUNT: level_total  = {28'b0, value[3:0]};
            default: ;
        endcase
        if (index != CFG_UNUSED)
            restart_image();
    endtask

    task automatic program_image(input int unsigned w, input int unsigned h,
                                 input int unsigned levels);
        wait_quiet();
        write_reg(bfmc_pkg::CFG_SRC_WIDTH, w[12:0]);
        write_reg(bfmc_pkg::CFG_SRC_HEIGHT, h[12:0]);
        write_reg(bfmc_pkg::CFG_LEVEL_COUNT, levels[12:0]);
    endtask

    task automatic send_pixel(input logic [31:0] pixel);
        pending_pixels.push_back(pixel);
        pixels_queued++;
    endtask

    task automatic send_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_pixel($urandom());
    endtask

    initial
    begin : stimulus
        int unsigned w, h, levels, area, count;
        int          phase, random_items, drain;
        restart_image();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Zero sizes read as one pixel square and a level count above the maximum
        // saturates, so each pixel runs down all twelve levels. The receiver holds
        // off meanwhile, the chain backs up and the source side has to stall.
        program_image(0, 0, 15);
        hold_request <= ~hold_request;
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8080_8080);
        send_pixel(32'h7F01_FE10);

        // Truncation of the average, then a second image right after the first.
        program_image(2, 2, 2);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0101_0101);
        send_random(4);

        // Odd size: the last column and row are dropped; level 1 is one texel and
        // level 2 reuses it by clamping.
        program_image(3, 3, 3);
        send_random(9);

        // A level count of zero or one produces nothing.
        wait_quiet();
        write_reg(bfmc_pkg::CFG_LEVEL_COUNT, 13'd0);
        send_random(2);
        wait_quiet();
        write_reg(bfmc_pkg::CFG_LEVEL_COUNT, 13'd1);
        send_random(1);

        // Widest and tallest images, cut short by the next write. A write to the
        // unused index halfway must leave the raster position alone.
        program_image(4096, 1, 13);
        send_random(40);
        program_image(1, 4096, 13);
        send_random(20);
        wait_quiet();
        write_reg(CFG_UNUSED, 13'($urandom_range(0, 8191)));
        send_random(20);

        // Random images, mostly complete and small, some cut short or repeated, a few
        // very wide or very tall. A stretch of phases runs with no idling at all.
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    w = $urandom_range(21, 4096);
                    h = 1;
                end
                else
                begin
                    w = $urandom_range(1, 2);
                    h = $urandom_range(21, 4096);
                end
                count = $urandom_range(8, 40);
            end
            else
            begin
                w = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(0, 12);
                h = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(0, 12);
                area = ((w != 0) ? w : 1) * ((h != 0) ? h : 1);
                case ($urandom_range(0, 9))
                    0, 1:    count = $urandom_range(1, area);
                    2:       count = 2 * area;
                    default: count = area;
                endcase
            end
            levels = $urandom_range(0, 15);
            steady <= (phase >= 3 && phase < 7);
            program_image(w, h, levels);
            send_random(count);
            random_items += count;
            phase++;
        end

        // Drain, with a bound of its own, then report anything still awaited.
        drain = 0;
        while ((pixels_taken != pixels_queued || awaited_texels.size() != 0) &&
               drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_texels.size() != 0)
            report_mismatch($sformatf("%0d texels never came out", awaited_texels.size()));

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
